// ===== src/ikc_pkg.sv =====
// ----------------------------------------------------------------------------
// ikc_pkg: shared types and constants for the index key comparator
// Beat kinds, type tags and the queue entry between front and back.
// ----------------------------------------------------------------------------
package ikc_pkg;

   typedef enum logic [1:0] {
      FUNC_HEADER  = 2'd0,
      FUNC_CHAR    = 2'd1,
      FUNC_KEY_HI  = 2'd2,
      FUNC_KEY_LO  = 2'd3
   } func_type;

   localparam logic [7:0] TAG_BOOL   = 8'd1;
   localparam logic [7:0] TAG_DOUBLE = 8'd2;
   localparam logic [7:0] TAG_STRING = 8'd3;

   localparam int unsigned ORDER_W = 17;
   localparam int unsigned CHAR_W  = 16;
   localparam int unsigned LEN_W   = 9;

   localparam logic [63:0] EXP_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

   // classified beat handed from front to back
   typedef enum logic [1:0] {
      OP_EMPTY  = 2'd0,   // answer immediately with the given value
      OP_START  = 2'd1,   // open frame, seed with a first result
      OP_CHAR   = 2'd2,   // char difference
      OP_KEY    = 2'd3    // key half compare (hi or lo)
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic                       key_lo;   // key beat is the low half
      logic                       is_string;
      logic signed [ORDER_W-1:0]  value;    // first result / char diff
      logic signed [ORDER_W-1:0]  len_diff;
      logic signed [1:0]          key_cmp;  // -1, 0, +1
   } ikc_entry_type;

   function automatic logic signed [1:0] cmp_u64(input logic [63:0] a, input logic [63:0] b);
      cmp_u64 = (a < b) ? -2'sd1 : ((a > b) ? 2'sd1 : 2'sd0);
   endfunction

   function automatic logic [63:0] order_key(input logic [63:0] bits);
      order_key = bits[63] ? ~bits : (bits | 64'h8000_0000_0000_0000);
   endfunction

endpackage

// ===== src/ikc_if.sv =====
// ----------------------------------------------------------------------------
// ikc_req_if / ikc_rsp_if: valid/ready channels
// Request beats in, ordering results out.
// ----------------------------------------------------------------------------
interface ikc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic        a_empty;
   logic        b_empty;
   logic [7:0]  a_type;
   logic [7:0]  b_type;
   logic [63:0] a_value;
   logic [63:0] b_value;
   logic [8:0]  a_len;
   logic [8:0]  b_len;
   logic [15:0] a_char;
   logic [15:0] b_char;
   modport source (output valid, func, a_empty, b_empty, a_type, b_type, a_value,
                   b_value, a_len, b_len, a_char, b_char, input ready);
   modport sink (input valid, func, a_empty, b_empty, a_type, b_type, a_value,
                 b_value, a_len, b_len, a_char, b_char, output ready);
endinterface

interface ikc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] order_value;
   modport source (output valid, order_value, input ready);
   modport sink (input valid, order_value, output ready);
endinterface

// ===== src/ikc_front.sv =====
// ----------------------------------------------------------------------------
// ikc_front: beat classifier
// Tracks the frame phase, drops ignored beats, and does the wide compares,
// pushing one compact entry per effective beat into the queue.
// ----------------------------------------------------------------------------
module ikc_front import ikc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ikc_req_if.sink        req,
   output logic           push_valid,
   output ikc_entry_type  push_entry,
   input  logic           push_ready
);

   logic [1:0]  key_phase_ff, key_phase_in;
   logic        is_string_ff, is_string_in;
   logic        take;
   logic [63:0] ma, mb;
   logic signed [1:0] dbl_cmp, bool_cmp;

   assign req.ready = push_ready;
   assign take      = req.valid && push_ready;

   // typed header compares
   always_comb begin
      ma = req.a_value & EXP_MASK;
      mb = req.b_value & EXP_MASK;
      if (ma > INF_BITS || mb > INF_BITS || (ma == '0 && mb == '0))
         dbl_cmp = 2'sd0;
      else
         dbl_cmp = cmp_u64(order_key(req.a_value), order_key(req.b_value));
      bool_cmp = cmp_u64({32'd0, ~req.a_value[31], req.a_value[30:0]},
                         {32'd0, ~req.b_value[31], req.b_value[30:0]});
   end

   // classification
   always_comb begin
      push_valid   = 1'b0;
      push_entry   = '0;
      key_phase_in = key_phase_ff;
      is_string_in = is_string_ff;
      push_entry.key_cmp = cmp_u64(req.a_value, req.b_value);
      case (func_type'(req.func))
         FUNC_HEADER: begin
            push_valid = 1'b1;
            is_string_in = (req.a_type == TAG_STRING);
            if (req.a_empty || req.b_empty) begin
               push_entry.op = OP_EMPTY;
               key_phase_in  = 2'd0;
               if (!req.b_empty)      push_entry.value = -17'sd1;
               else if (!req.a_empty) push_entry.value = 17'sd1;
            end else begin
               push_entry.op = OP_START;
               key_phase_in  = 2'd1;
               if (req.a_type != req.b_type)
                  push_entry.value = $signed({9'd0, req.a_type}) - $signed({9'd0, req.b_type});
               else if (req.a_type == TAG_BOOL)
                  push_entry.value = ORDER_W'(bool_cmp);
               else if (req.a_type == TAG_DOUBLE)
                  push_entry.value = ORDER_W'(dbl_cmp);
               else if (req.a_type == TAG_STRING)
                  push_entry.len_diff = $signed({8'd0, req.a_len}) - $signed({8'd0, req.b_len});
            end
         end
         FUNC_CHAR: begin
            push_entry.op    = OP_CHAR;
            push_entry.value = $signed({1'b0, req.a_char}) - $signed({1'b0, req.b_char});
            push_valid = (key_phase_ff == 2'd1) && is_string_ff;
         end
         FUNC_KEY_HI: begin
            push_entry.op = OP_KEY;
            push_valid    = (key_phase_ff == 2'd1);
            if (key_phase_ff == 2'd1) key_phase_in = 2'd2;
         end
         FUNC_KEY_LO: begin
            push_entry.op     = OP_KEY;
            push_entry.key_lo = 1'b1;
            push_valid        = (key_phase_ff == 2'd2);
            if (key_phase_ff == 2'd2) key_phase_in = 2'd0;
         end
         default: ;
      endcase
      push_valid = push_valid && req.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_phase_ff <= 2'd0;
         is_string_ff <= 1'b0;
      end else if (take) begin
         key_phase_ff <= key_phase_in;
         is_string_ff <= is_string_in;
      end
   end

endmodule

// ===== src/ikc_queue.sv =====
// ----------------------------------------------------------------------------
// ikc_queue: small FIFO between front and back
// Register-based; push and pop can happen together, but push_ready is low while full.
// ----------------------------------------------------------------------------
module ikc_queue import ikc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  ikc_entry_type  push_entry,
   output logic           push_ready,
   output logic           pop_valid,
   output ikc_entry_type  pop_entry,
   input  logic           pop_ready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ikc_entry_type       mem_ff [DEPTH];
   logic [AW-1:0]       wr_ff, rd_ff;
   logic [AW:0]         cnt_ff;
   logic                push, pop;

   assign push_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   // pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

// ===== src/ikc_back.sv =====
// ----------------------------------------------------------------------------
// ikc_back: result accumulator
// Holds the first nonzero difference of the frame and emits it through an
// output register on the low key beat or on an empty-key header.
// ----------------------------------------------------------------------------
module ikc_back import ikc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   input  ikc_entry_type  pop_entry,
   output logic           pop_ready,
   ikc_rsp_if.source      rsp
);

   logic                      decided_ff, decided_in;
   logic signed [ORDER_W-1:0] held_ff, held_in;
   logic signed [ORDER_W-1:0] len_ff, len_in;
   logic                      out_valid_ff;
   logic signed [ORDER_W-1:0] out_ff;
   logic                      emit;
   logic signed [ORDER_W-1:0] emit_val;
   logic                      take;

   assign pop_ready       = !out_valid_ff || rsp.ready;
   assign take            = pop_valid && pop_ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.order_value = out_ff;

   // hold the first nonzero difference
   always_comb begin
      decided_in = decided_ff;
      held_in    = held_ff;
      len_in     = len_ff;
      emit       = 1'b0;
      emit_val   = pop_entry.value;
      case (pop_entry.op)
         OP_EMPTY: emit = 1'b1;
         OP_START: begin
            decided_in = (pop_entry.value != '0);
            held_in    = pop_entry.value;
            len_in     = pop_entry.len_diff;
         end
         OP_CHAR: begin
            if (!decided_ff && pop_entry.value != '0) begin
               decided_in = 1'b1;
               held_in    = pop_entry.value;
            end
         end
         OP_KEY: begin
            if (!decided_ff && !pop_entry.key_lo && len_ff != '0) begin
               decided_in = 1'b1;
               held_in    = len_ff;
            end else if (!decided_ff && pop_entry.key_cmp != 2'sd0) begin
               decided_in = 1'b1;
               held_in    = ORDER_W'(pop_entry.key_cmp);
            end
            emit     = pop_entry.key_lo;
            emit_val = held_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decided_ff   <= 1'b0;
         held_ff      <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            decided_ff <= decided_in;
            held_ff    <= held_in;
            len_ff     <= len_in;
         end
         if (take && emit) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) out_ff <= emit_val;
   end

endmodule

// ===== src/index_key_compare_top.sv =====
// ----------------------------------------------------------------------------
// index_key_compare_top: three-way comparator for serialized index keys
// Front classifies beats, a queue decouples, back accumulates the result.
//
//   channel | dir | handshake       | payload
//   req     | in  | valid / ready   | func, empties, types, values, lens, chars
//   rsp     | out | valid / ready   | order_value (17-bit signed)
//
// One beat per cycle while the queue is not full; a result goes through the queue and the back's output register.
// The wide 64-bit compares sit in the front, before the queue.
// Synchronous active-high reset empties the queue and closes any frame.
// A stalled rsp fills the queue; req.ready drops only when it is full.
// ----------------------------------------------------------------------------
module index_key_compare_top import ikc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   ikc_req_if.sink   req,
   ikc_rsp_if.source rsp
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   ikc_entry_type push_entry, pop_entry;

   ikc_front u_front (
      .clock, .reset, .req,
      .push_valid, .push_entry, .push_ready
   );

   ikc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .push_valid, .push_entry, .push_ready,
      .pop_valid, .pop_entry, .pop_ready
   );

   ikc_back u_back (
      .clock, .reset,
      .pop_valid, .pop_entry, .pop_ready, .rsp
   );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for index_key_compare_top
// Drives header, char and key beats as frames with random content plus
// noise, predicts each ordering result and checks it against the rsp channel.
// ----------------------------------------------------------------------------
module tb;
   import ikc_pkg::*;

   typedef struct {
      logic [1:0]  func;
      logic        a_empty;
      logic        b_empty;
      logic [7:0]  a_type;
      logic [7:0]  b_type;
      logic [63:0] a_value;
      logic [63:0] b_value;
      logic [8:0]  a_len;
      logic [8:0]  b_len;
      logic [15:0] a_char;
      logic [15:0] b_char;
   } beat_type;

   logic clock;
   logic reset;

   ikc_req_if req ();
   ikc_rsp_if rsp ();

   index_key_compare_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   beat_type           pending_beats[$];
   logic signed [16:0] expected_orders[$];
   int                 errors;
   int                 beats_sent;
   int                 orders_seen;
   bit                 calm;
   int                 req_idle;
   int                 rsp_idle;

   // predictor state
   bit                 p_decided;
   logic signed [16:0] p_held;
   logic [7:0]         p_type;
   logic signed [16:0] p_len_diff;
   logic [1:0]         p_phase;

   function automatic logic signed [16:0] ucmp(logic [63:0] a, logic [63:0] b);
      return (a < b) ? -17'sd1 : ((a > b) ? 17'sd1 : 17'sd0);
   endfunction

   function automatic logic [63:0] dbl_key(logic [63:0] bits);
      return bits[63] ? ~bits : (bits | 64'h8000_0000_0000_0000);
   endfunction

   function automatic logic signed [16:0] dbl_cmp(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      ma = a & EXP_MASK;
      mb = b & EXP_MASK;
      if (ma > INF_BITS || mb > INF_BITS) return 17'sd0;
      if (ma == 64'd0 && mb == 64'd0) return 17'sd0;
      return ucmp(dbl_key(a), dbl_key(b));
   endfunction

   function automatic void keep_first(logic signed [16:0] r);
      if (!p_decided && r != 17'sd0) begin
         p_decided = 1;
         p_held = r;
      end
   endfunction

   // ordering predictor: one accepted beat, maybe one expected result
   function automatic void predict_order(beat_type b);
      case (b.func)
         FUNC_HEADER: begin
            p_decided = 0;
            p_held = 0;
            p_type = b.a_type;
            p_len_diff = 0;
            if (b.a_empty || b.b_empty) begin
               p_phase = 0;
               if (!b.b_empty) expected_orders.push_back(-17'sd1);
               else if (!b.a_empty) expected_orders.push_back(17'sd1);
               else expected_orders.push_back(17'sd0);
            end else begin
               p_phase = 1;
               if (b.a_type != b.b_type)
                  keep_first($signed({9'd0, b.a_type}) - $signed({9'd0, b.b_type}));
               else if (b.a_type == TAG_BOOL)
                  keep_first(ucmp({32'd0, b.a_value[31:0] ^ 32'h8000_0000},
                                  {32'd0, b.b_value[31:0] ^ 32'h8000_0000}));
               else if (b.a_type == TAG_DOUBLE)
                  keep_first(dbl_cmp(b.a_value, b.b_value));
               else if (b.a_type == TAG_STRING)
                  p_len_diff = $signed({8'd0, b.a_len}) - $signed({8'd0, b.b_len});
            end
         end
         FUNC_CHAR: begin
            if (p_phase == 1 && p_type == TAG_STRING)
               keep_first($signed({1'b0, b.a_char}) - $signed({1'b0, b.b_char}));
         end
         FUNC_KEY_HI: begin
            if (p_phase == 1) begin
               keep_first(p_len_diff);
               keep_first(ucmp(b.a_value, b.b_value));
               p_phase = 2;
            end
         end
         default: begin
            if (p_phase == 2) begin
               keep_first(ucmp(b.a_value, b.b_value));
               p_phase = 0;
               expected_orders.push_back(p_held);
            end
         end
      endcase
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [7:0] rnd_tag();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1, 2: return TAG_BOOL;
         3, 4: return TAG_DOUBLE;
         5, 6, 7: return TAG_STRING;
         8: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [63:0] rnd_double();
      case ($urandom_range(0, 7))
         0: return 64'h0;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'h7FF0_0000_0000_0000;
         3: return 64'hFFF0_0000_0000_0000;
         4: return 64'h7FF8_0000_0000_0001;
         5: return 64'h3FF0_0000_0000_0000 ^ {1'($urandom_range(0, 1)), 63'd0};
         default: return rnd64();
      endcase
   endfunction

   function automatic beat_type any_beat();
      beat_type b;
      b.func = 2'($urandom_range(0, 3));
      b.a_empty = 1'($urandom_range(0, 1));
      b.b_empty = 1'($urandom_range(0, 1));
      b.a_type = 8'($urandom_range(0, 255));
      b.b_type = 8'($urandom_range(0, 255));
      b.a_value = rnd64();
      b.b_value = rnd64();
      b.a_len = 9'($urandom_range(0, 511));
      b.b_len = 9'($urandom_range(0, 511));
      b.a_char = 16'($urandom_range(0, 65535));
      b.b_char = 16'($urandom_range(0, 65535));
      return b;
   endfunction

   // one frame: header and, unless a side is empty, char pairs (at most one for non-strings) and two key beats
   task automatic push_frame(logic [7:0] ta, logic [7:0] tb_, bit ae, bit be,
                             logic [63:0] va, logic [63:0] vb,
                             int la, int lb, bit close_chars, bit same_keys);
      beat_type b;
      int n;
      logic [15:0] c;
      b = any_beat();
      b.func = FUNC_HEADER;
      b.a_empty = ae;
      b.b_empty = be;
      b.a_type = ta;
      b.b_type = tb_;
      b.a_value = va;
      b.b_value = vb;
      b.a_len = 9'(la);
      b.b_len = 9'(lb);
      pending_beats.push_back(b);
      if (ae || be) return;
      n = (la < lb) ? la : lb;
      if (ta != TAG_STRING) n = int'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
         b = any_beat();
         b.func = FUNC_CHAR;
         if (close_chars && $urandom_range(0, 7) != 0) begin
            c = 16'($urandom_range(0, 65535));
            b.a_char = c;
            b.b_char = c;
         end
         pending_beats.push_back(b);
      end
      b = any_beat();
      b.func = FUNC_KEY_HI;
      if (same_keys) b.b_value = b.a_value;
      pending_beats.push_back(b);
      b = any_beat();
      b.func = FUNC_KEY_LO;
      if (same_keys) b.b_value = b.a_value;
      pending_beats.push_back(b);
   endtask

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // stimulus
   initial begin
      beat_type b;
      logic [7:0] t;
      errors = 0;
      // directed: empties, type mismatch, bools, doubles, strings, keys
      push_frame(TAG_STRING, TAG_STRING, 1, 1, 0, 0, 0, 0, 0, 0);
      push_frame(TAG_STRING, TAG_STRING, 1, 0, 0, 0, 0, 0, 0, 0);
      push_frame(TAG_STRING, TAG_STRING, 0, 1, 0, 0, 0, 0, 0, 0);
      push_frame(8'd0, 8'd255, 0, 0, 0, 0, 0, 0, 0, 0);
      push_frame(8'd255, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_frame(TAG_BOOL, TAG_BOOL, 0, 0, 64'h8000_0000, 64'h7FFF_FFFF, 0, 0, 0, 0);
      push_frame(TAG_DOUBLE, TAG_DOUBLE, 0, 0, 64'h8000_0000_0000_0000, 64'h0, 0, 0,
                 0, 1);
      push_frame(TAG_DOUBLE, TAG_DOUBLE, 0, 0, 64'h7FF8_0000_0000_0000,
                 64'h3FF0_0000_0000_0000, 0, 0, 0, 0);
      push_frame(TAG_DOUBLE, TAG_DOUBLE, 0, 0, 64'hFFF0_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 0, 0, 0, 0);
      push_frame(TAG_STRING, TAG_STRING, 0, 0, 0, 0, 256, 0, 1, 1);
      push_frame(TAG_STRING, TAG_STRING, 0, 0, 0, 0, 3, 3, 0, 0);
      push_frame(8'd128, 8'd128, 0, 0, 0, 0, 0, 0, 0, 0);
      // noise: stray key beats, header dropped by a new header
      b = any_beat(); b.func = FUNC_KEY_LO; pending_beats.push_back(b);
      b = any_beat(); b.func = FUNC_KEY_HI; pending_beats.push_back(b);
      b = any_beat(); b.func = FUNC_HEADER; b.a_empty = 0; b.b_empty = 0;
      pending_beats.push_back(b);
      push_frame(TAG_BOOL, TAG_BOOL, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1);
      // random: mostly well-formed frames, some raw noise
      while (pending_beats.size() < 420) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_beats.push_back(any_beat());
         end else begin
            t = rnd_tag();
            push_frame(t, ($urandom_range(0, 4) == 0) ? rnd_tag() : t,
                       $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                       (t == TAG_DOUBLE) ? rnd_double() : rnd64(),
                       (t == TAG_DOUBLE) ? rnd_double() : rnd64(),
                       ($urandom_range(0, 19) == 0) ? 256 : int'($urandom_range(0, 6)),
                       ($urandom_range(0, 19) == 0) ? 256 : int'($urandom_range(0, 6)),
                       $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
         end
      end
   end

   // reset and the end of the run
   initial begin
      reset = 1;
      calm = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (beats_sent > 300);
      calm = 1;
      wait (pending_beats.size() == 0 && expected_orders.size() == 0);
      repeat (10) @(posedge clock);
      if (expected_orders.size() != 0) begin
         $error("expected order results left over: %0d", expected_orders.size());
         errors++;
      end
      $display("covered %0d request beats and %0d ordering results", beats_sent,
               orders_seen);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // driver: the head of the queue is the beat on the bus until accepted
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.func <= FUNC_HEADER;
         req.a_empty <= 0;
         req.b_empty <= 0;
         req.a_type <= 0;
         req.b_type <= 0;
         req.a_value <= 0;
         req.b_value <= 0;
         req.a_len <= 0;
         req.b_len <= 0;
         req.a_char <= 0;
         req.b_char <= 0;
         req_idle <= 0;
         beats_sent <= 0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            predict_order(pending_beats.pop_front());
            beats_sent <= beats_sent + 1;
         end
         if (req_idle > 0) begin
            req.valid <= 0;
            req_idle <= req_idle - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req.valid <= 0;
            req_idle <= int'($urandom_range(0, 3));
         end else if (pending_beats.size() > 0) begin
            beat_type b;
            b = pending_beats[0];
            req.valid <= 1;
            req.func <= b.func;
            req.a_empty <= b.a_empty;
            req.b_empty <= b.b_empty;
            req.a_type <= b.a_type;
            req.b_type <= b.b_type;
            req.a_value <= b.a_value;
            req.b_value <= b.b_value;
            req.a_len <= b.a_len;
            req.b_len <= b.b_len;
            req.a_char <= b.a_char;
            req.b_char <= b.b_char;
         end else begin
            req.valid <= 0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         rsp_idle <= 0;
         orders_seen <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            orders_seen <= orders_seen + 1;
            if (expected_orders.size() == 0) begin
               $error("unexpected order_value %0d", rsp.order_value);
               errors++;
            end else begin
               logic signed [16:0] want;
               want = expected_orders.pop_front();
               if (rsp.order_value !== want) begin
                  $error("order_value expected %0d actual %0d", want, rsp.order_value);
                  errors++;
               end
            end
         end
         if (rsp_idle > 0) begin
            rsp.ready <= 0;
            rsp_idle <= rsp_idle - 1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 0;
            rsp_idle <= int'($urandom_range(0, 3));
         end else begin
            rsp.ready <= 1;
         end
      end
   end
endmodule
